// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define WMA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wma assertion failed");

// clocked assertion, checked during reset as well
`define WMA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wma assertion failed");

`endif

// ----- rtl/wma_pkg.sv -----
// ----------------------------------------------------------------------------
// wma_pkg
// Shared widths, types and defaults of the weighted moving average block.
// ----------------------------------------------------------------------------
package wma_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned WINDOW_DEF = 10;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// ----- rtl/wma_ram.sv -----
// ----------------------------------------------------------------------------
// wma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read and a write to the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module wma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/weighted_moving_average_top.sv -----
// Pipeline: a word accepted moves through the ring read, running sum and
//   reciprocal product registers before its result is valid.
// Throughput: one word per cycle while the output is not stalled; the sample
//   ring does one read and one write per word, running sums update once per word.
// Reset (async, active low): running sums, fill count and ring pointer clear;
//   ring entries not yet written since reset read as zero via the fill count.
// ----------------------------------------------------------------------------
// weighted_moving_average_top
// Linearly weighted moving average over the last WINDOW samples. The window
// lives in a ring RAM; running plain and weighted sums are updated from the
// sample leaving the window, and the mean comes from a reciprocal multiply.
// ----------------------------------------------------------------------------
module weighted_moving_average_top #(
  parameter int unsigned WINDOW = wma_pkg::WINDOW_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wma_pkg::sample_t sample_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output wma_pkg::sample_t smoothed_o,
  output logic             window_full_o
);

  import wma_pkg::*;

  localparam int unsigned TOTAL   = WINDOW * (WINDOW + 1) / 2;
  localparam int unsigned SMAX    = (1 << SAMPLE_W) - 1;
  localparam int unsigned SSUM_W  = $clog2(SMAX * WINDOW + 1);
  localparam int unsigned WSUM_W  = $clog2(SMAX * TOTAL + 1);
  localparam int unsigned SHIFT   = WSUM_W + $clog2(TOTAL);
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);
  localparam int unsigned RECIP_W = $clog2(RECIP_L + 64'd1);
  localparam int unsigned PROD_W  = WSUM_W + RECIP_W;
  localparam int unsigned ADDR_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W  = $clog2(WINDOW + 1);

  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);
  localparam logic [WSUM_W-1:0]  WIN_K   = WSUM_W'(WINDOW);
  localparam logic [FILL_W-1:0]  FILL_MAX = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0]  FILL_PRE = FILL_W'(WINDOW - 1);
  localparam logic [ADDR_W-1:0]  PTR_LAST = ADDR_W'(WINDOW - 1);

  logic              advance;
  logic              accept;

  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  sample_t           old_rd;
  sample_t           old_s;

  // stage 1: ring read in flight
  logic              v1_q;
  sample_t           x1_q;
  logic              old_ok1_q;
  logic              full1_q;

  // stage 2: running sums updated
  logic              v2_q;
  sample_t           x2_q;
  logic              full2_q;
  logic [SSUM_W-1:0] ssum_q, ssum_d;
  logic [WSUM_W-1:0] wsum_q, wsum_d;

  // stage 3: reciprocal product, output register
  logic              v3_q;
  sample_t           x3_q;
  logic              full3_q;
  logic [PROD_W-1:0] prod_q, prod_d;

  assign advance    = !v3_q || out_ready_i;
  assign accept     = in_valid_i && advance;
  assign in_ready_o = advance;

  wma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .re_i    (accept),
    .raddr_i (wp_q),
    .rdata_o (old_rd)
  );

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (accept) begin
      wp_d = (wp_q == PTR_LAST) ? '0 : wp_q + ADDR_W'(1);
      if (fill_q != FILL_MAX) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  // entry leaving the window is zero until the ring has wrapped once
  assign old_s  = old_ok1_q ? old_rd : '0;
  assign ssum_d = ssum_q - SSUM_W'(old_s) + SSUM_W'(x1_q);
  assign wsum_d = wsum_q - WSUM_W'(ssum_q) + WSUM_W'(x1_q) * WIN_K;
  assign prod_d = PROD_W'(wsum_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      ssum_q <= '0;
      wsum_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      if (advance) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q;
        if (v1_q) begin
          ssum_q <= ssum_d;
          wsum_q <= wsum_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x1_q      <= sample_i;
      old_ok1_q <= (fill_q == FILL_MAX);
      full1_q   <= (fill_q >= FILL_PRE);
      x2_q      <= x1_q;
      full2_q   <= full1_q;
      x3_q      <= x2_q;
      full3_q   <= full2_q;
      prod_q    <= prod_d;
    end
  end

  assign out_valid_o   = v3_q;
  assign window_full_o = full3_q;
  assign smoothed_o    = full3_q ? prod_q[SHIFT +: SAMPLE_W] : x3_q;

endmodule

// ----- rtl/wma_checker.sv -----
// ----------------------------------------------------------------------------
// wma_checker
// Port-level checks of the weighted moving average block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wma_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input wma_pkg::sample_t smoothed_o,
  input logic             window_full_o
);

  import wma_pkg::*;

  logic              in_take;
  logic              out_stall;
  logic              out_take;
  logic              raw_out;
  logic [SAMPLE_W:0] out_word;

  assign in_take   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_take  = out_valid_o && out_ready_i;
  assign raw_out   = out_valid_o && !window_full_o;
  assign out_word  = {smoothed_o, window_full_o};

  // stalled result word holds
  `WMA_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_word))

  // input side only stalls behind a stalled output
  `WMA_ASSERT(a_ready_rule, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i))

  // once a full-window word goes out, the next word is also full-window
  `WMA_ASSERT(a_full_sticky, clk_i, rst_ni, out_take && window_full_o |=> !raw_out)

  // nothing comes out during reset
  `WMA_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o)

  // accepted word shows up once out_ready_i has held while it moved through the pipeline
  `WMA_ASSERT(a_in_to_out, clk_i, rst_ni, in_take ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)

endmodule

bind weighted_moving_average_top wma_checker u_wma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .smoothed_o    (smoothed_o),
  .window_full_o (window_full_o)
);
